// File: sv/dbad_pkg.sv
package dbad_pkg;

    // storage geometry
    localparam int MAIN_RAM_BYTES = 2048;
    localparam int MAIN_AW        = $clog2(MAIN_RAM_BYTES);
    localparam int BANK_BYTES     = 8192;
    localparam int BANK_AW        = $clog2(BANK_BYTES);
    localparam int XRAM_BANKS     = 5;
    localparam int XRAM_DEPTH     = XRAM_BANKS * BANK_BYTES;
    localparam int XRAM_AW        = $clog2(XRAM_DEPTH);
    localparam int BANK_SEL_W     = XRAM_AW - BANK_AW;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 15;

    localparam logic [CFG_IW-1:0] REG_DRIVE_FAMILY   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_EXPANSION_MASK = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SCRAMBLED_ROM  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_XROM_PRESENT   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_ROM_MASK       = 3'd4;

    localparam logic [14:0] ROM_MASK_RESET = 15'h3FFF;

    // access targets
    localparam logic [3:0] TGT_NONE = 4'd0;
    localparam logic [3:0] TGT_RAM  = 4'd1;
    localparam logic [3:0] TGT_XRAM = 4'd2;
    localparam logic [3:0] TGT_VIA1 = 4'd3;
    localparam logic [3:0] TGT_VIA2 = 4'd4;
    localparam logic [3:0] TGT_CIA  = 4'd5;
    localparam logic [3:0] TGT_CTRL = 4'd6;
    localparam logic [3:0] TGT_ROM  = 4'd7;
    localparam logic [3:0] TGT_XROM = 4'd8;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  write_data;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  target;
        logic [7:0]  read_data;
        logic [14:0] device_addr;
        logic        clears_byte_ready;
    } t_out_word;

endpackage

// File: sv/drive_bus_address_decoder.sv
// Decodes one drive CPU bus access per word to a target (RAM, expansion RAM bank, VIA1,
// VIA2, CIA, controller, ROM, expanded ROM or unmapped). Main RAM (2 KiB, mirrored) and
// the five 8 KiB expansion banks are single-port synchronous memories inside the block;
// their read data is registered as the access is taken and joins the word as it leaves
// the middle stage for the output register; a new access is taken every clock as long as
// the output side keeps up. After reset both memories are zeroed by a clearing pass (one
// expansion byte per cycle, main RAM alongside the first 2048 addresses); o_in_stall stays
// high for that time. Configuration writes are always taken (o_cfg_ready is constant high)
// and must only be issued while no access is in flight.
module drive_bus_address_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  dbad_pkg::t_in_word           i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output dbad_pkg::t_out_word          o_out_word,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [dbad_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [dbad_pkg::CFG_DW-1:0]  i_cfg_data
);
    import dbad_pkg::*;

    // read data source of the word in the middle stage
    localparam logic [1:0] RSEL_CONST = 2'd0;
    localparam logic [1:0] RSEL_MAIN  = 2'd1;
    localparam logic [1:0] RSEL_XRAM  = 2'd2;

    localparam logic [XRAM_AW-1:0] CLR_LAST = XRAM_AW'(XRAM_DEPTH - 1);
    localparam logic [XRAM_AW-1:0] CLR_MAIN_END = XRAM_AW'(MAIN_RAM_BYTES);

    // configuration
    logic        r_drive_family;
    logic [4:0]  r_expansion_mask;
    logic        r_scrambled_rom;
    logic        r_xrom_present;
    logic [14:0] r_rom_mask;
    logic [3:0]  r_nibble;

    // clearing pass
    logic               r_clr_busy;
    logic [XRAM_AW-1:0] r_clr_addr;

    // memories
    logic [7:0] r_main_mem [MAIN_RAM_BYTES];
    logic [7:0] r_xram_mem [XRAM_DEPTH];
    logic [7:0] r_main_q;
    logic [7:0] r_xram_q;

    // pipeline
    logic       r_s1_valid;
    t_out_word  r_s1_word;
    logic [1:0] r_s1_rsel;
    logic       r_out_valid;
    t_out_word  r_out_word;
    t_out_word  n_out_word;

    logic in_acc;
    logic s1_move;
    logic cfg_acc;

    // decode
    logic [7:0]            page;
    logic [3:0]            dec_tgt;
    logic [BANK_SEL_W-1:0] dec_bank;
    logic [BANK_SEL_W-1:0] low_bank;
    logic [BANK_SEL_W-1:0] high_bank;

    // access result
    t_out_word   n_word;
    logic [1:0]  n_rsel;
    logic        n_nibble_we;
    logic [3:0]  n_nibble;
    logic [15:0] scr_addr;
    logic        is_wr;

    // memory ports
    logic               main_we;
    logic               main_re;
    logic [MAIN_AW-1:0] main_a;
    logic [7:0]         main_wd;
    logic               xram_we;
    logic               xram_re;
    logic [XRAM_AW-1:0] xram_a;
    logic [7:0]         xram_wd;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_move);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign page  = i_in_word.addr[15:8];
    assign is_wr = (i_in_word.op == OP_WRITE);

    assign low_bank  = BANK_SEL_W'(page[7:5] - 3'd1);
    assign high_bank = (page >= 8'hA0) ? BANK_SEL_W'(4) : BANK_SEL_W'(3);

    always_comb begin
        dec_tgt  = TGT_NONE;
        dec_bank = '0;
        if (!r_drive_family) begin
            if (page >= 8'hC0) begin
                dec_tgt = TGT_ROM;
            end else if (page >= 8'h80) begin
                if (r_expansion_mask[high_bank]) begin
                    dec_tgt  = TGT_XRAM;
                    dec_bank = high_bank;
                end else begin
                    dec_tgt = TGT_ROM;
                end
            end else if (page >= 8'h20 && r_expansion_mask[low_bank]) begin
                dec_tgt  = TGT_XRAM;
                dec_bank = low_bank;
            end else if (page[4:0] <= 5'h07) begin
                dec_tgt = TGT_RAM;
            end else if (page[4:0] >= 5'h1C) begin
                dec_tgt = TGT_VIA2;
            end else if (page[4:0] >= 5'h18) begin
                dec_tgt = TGT_VIA1;
            end
        end else begin
            if (page >= 8'h80) begin
                dec_tgt = TGT_ROM;
            end else if (page >= 8'h60) begin
                if (r_scrambled_rom) begin
                    dec_tgt = TGT_XROM;
                end else if (r_expansion_mask[2]) begin
                    dec_tgt  = TGT_XRAM;
                    dec_bank = BANK_SEL_W'(2);
                end else begin
                    dec_tgt = TGT_CIA;
                end
            end else if (page >= 8'h40) begin
                if (r_expansion_mask[1] && page >= 8'h48) begin
                    dec_tgt  = TGT_XRAM;
                    dec_bank = BANK_SEL_W'(1);
                end else begin
                    dec_tgt = TGT_CIA;
                end
            end else if (page >= 8'h30) begin
                dec_tgt = TGT_NONE;
            end else if (page >= 8'h20) begin
                dec_tgt = TGT_CTRL;
            end else if (page >= 8'h1C) begin
                dec_tgt = TGT_VIA2;
            end else if (page >= 8'h18) begin
                dec_tgt = TGT_VIA1;
            end else if (page <= 8'h0F) begin
                dec_tgt = TGT_RAM;
            end
        end
    end

    // expanded rom address scramble through the nibble register
    always_comb begin
        if (!i_in_word.addr[11]) begin
            scr_addr = {i_in_word.addr[15:8], r_nibble, i_in_word.addr[3:0]};
        end else begin
            scr_addr = {i_in_word.addr[15:8], r_nibble, i_in_word.addr[7:4]};
        end
    end

    always_comb begin
        n_word             = '0;
        n_word.target      = dec_tgt;
        n_rsel             = RSEL_CONST;
        n_nibble_we        = 1'b0;
        n_nibble           = scr_addr[3:0];
        case (dec_tgt)
            TGT_RAM: begin
                if (!is_wr) n_rsel = RSEL_MAIN;
            end
            TGT_XRAM: begin
                if (!is_wr) n_rsel = RSEL_XRAM;
            end
            TGT_VIA1, TGT_CIA: begin
                n_word.device_addr = {11'd0, i_in_word.addr[3:0]};
            end
            TGT_VIA2: begin
                n_word.device_addr       = {11'd0, i_in_word.addr[3:0]};
                n_word.clears_byte_ready = 1'b1;
            end
            TGT_CTRL: begin
                n_word.device_addr = {13'd0, i_in_word.addr[1:0]};
            end
            TGT_ROM: begin
                if (is_wr) begin
                    n_word.target = TGT_NONE;
                end else begin
                    n_word.device_addr = i_in_word.addr[14:0] & r_rom_mask;
                end
            end
            TGT_XROM: begin
                if (is_wr) begin
                    n_word.target = TGT_NONE;
                end else if (!r_xrom_present) begin
                    n_word.read_data = 8'hFF;
                end else if (i_in_word.addr >= 16'h7000) begin
                    n_word.device_addr = {2'd0, scr_addr[12:0]};
                    n_nibble_we        = 1'b1;
                end else begin
                    n_word.device_addr = {2'd0, i_in_word.addr[12:0]};
                end
            end
            default: begin
                if (!is_wr) n_word.read_data = i_in_word.addr[15:8];
            end
        endcase
    end

    // memory port muxing: the clearing pass owns both ports until it ends
    always_comb begin
        if (r_clr_busy) begin
            main_we = (r_clr_addr < CLR_MAIN_END);
            main_a  = r_clr_addr[MAIN_AW-1:0];
            main_wd = 8'd0;
            xram_we = 1'b1;
            xram_a  = r_clr_addr;
            xram_wd = 8'd0;
        end else begin
            main_we = in_acc && (dec_tgt == TGT_RAM) && is_wr;
            main_a  = i_in_word.addr[MAIN_AW-1:0];
            main_wd = i_in_word.write_data;
            xram_we = in_acc && (dec_tgt == TGT_XRAM) && is_wr;
            xram_a  = {dec_bank, i_in_word.addr[BANK_AW-1:0]};
            xram_wd = i_in_word.write_data;
        end
    end

    assign main_re = in_acc && (dec_tgt == TGT_RAM) && !is_wr;
    assign xram_re = in_acc && (dec_tgt == TGT_XRAM) && !is_wr;

    always_ff @(posedge i_clk) begin
        if (main_we) r_main_mem[main_a] <= main_wd;
        if (main_re) r_main_q <= r_main_mem[main_a];
    end

    always_ff @(posedge i_clk) begin
        if (xram_we) r_xram_mem[xram_a] <= xram_wd;
        if (xram_re) r_xram_q <= r_xram_mem[xram_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) r_clr_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_family   <= 1'b0;
            r_expansion_mask <= '0;
            r_scrambled_rom  <= 1'b0;
            r_xrom_present   <= 1'b0;
            r_rom_mask       <= ROM_MASK_RESET;
            r_nibble         <= '0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg_index)
                    REG_DRIVE_FAMILY:   r_drive_family   <= i_cfg_data[0];
                    REG_EXPANSION_MASK: r_expansion_mask <= i_cfg_data[4:0];
                    REG_SCRAMBLED_ROM:  r_scrambled_rom  <= i_cfg_data[0];
                    REG_XROM_PRESENT:   r_xrom_present   <= i_cfg_data[0];
                    REG_ROM_MASK:       r_rom_mask       <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && n_nibble_we) r_nibble <= n_nibble;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // memory read data joins the word as it leaves the middle stage
    always_comb begin
        n_out_word = r_s1_word;
        case (r_s1_rsel)
            RSEL_MAIN: n_out_word.read_data = r_main_q;
            RSEL_XRAM: n_out_word.read_data = r_xram_q;
            default:   n_out_word.read_data = r_s1_word.read_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_word <= n_word;
            r_s1_rsel <= n_rsel;
        end
        if (s1_move) begin
            r_out_word <= n_out_word;
        end
    end

    // the clearing pass runs once after reset and never again
    a_clr_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$rose(r_clr_busy))
        else $error("clearing pass restarted");

    // an accepted access always lands in the middle stage
    a_acc_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted access lost");

    // a held middle stage is not dropped while the output is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> r_s1_valid)
        else $error("middle stage dropped under stall");

    // byte-ready clear comes only with a via2 target
    a_clr_via2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.clears_byte_ready) |-> (o_out_word.target == TGT_VIA2))
        else $error("byte-ready clear on non-via2 access");

endmodule
